@@ design/wpp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the weighted pitch picker
// no dependencies
package wpp_pkg;

	localparam int CLASS_COUNT_DEF = 12;
	localparam int WEIGHT_W        = 7;
	localparam int CLASS_W         = 4;
	localparam int NOTE_W          = 7;
	localparam int OCTAVE_W        = 4;
	localparam int CHANNEL_W       = 5;
	localparam int OFFSET_W        = 7;
	localparam int CFG_DATA_W      = 42;
	localparam int CFG_INDEX_W     = 3;
	localparam int CLASSES_PER_REG = 6;
	localparam int NOTES_PER_OCTAVE = 12;
	localparam int RELOAD_CLASSES  = 2 * CLASSES_PER_REG;

	localparam logic [NOTE_W-1:0]    NOTE_MAX        = 7'd127;
	localparam logic [CHANNEL_W-1:0] MIDI_CHANNEL_RST = 5'd1;

	typedef enum logic [1:0] {
		STEP_NOTE    = 2'd0,
		STEP_REST    = 2'd1,
		STEP_NEITHER = 2'd2
	} step_kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DROP_AMOUNT     = 3'd0,
		CFG_RESET_LEVEL     = 3'd1,
		CFG_OCTAVE_A        = 3'd2,
		CFG_OCTAVE_B        = 3'd3,
		CFG_RELOAD_LOW_SIX  = 3'd4,
		CFG_RELOAD_HIGH_SIX = 3'd5,
		CFG_MIDI_CHANNEL    = 3'd6
	} cfg_reg_t;

	// result of the weight scan
	typedef struct packed {
		logic                found;
		logic [CLASS_W-1:0]  idx;
		logic [WEIGHT_W-1:0] best;
	} pick_t;

endpackage

@@ design/wpp_step_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one sequencer step word
// depends on wpp_pkg
interface wpp_step_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         step_kind;
	logic signed [wpp_pkg::OFFSET_W-1:0] note_offset;
	logic [wpp_pkg::OCTAVE_W-1:0]       octave_choice;

	modport source (output valid, step_kind, note_offset, octave_choice, input ready);
	modport sink (input valid, step_kind, note_offset, octave_choice, output ready);
endinterface

@@ design/wpp_event_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one note event word
// depends on wpp_pkg
interface wpp_event_if;
	logic                          valid;
	logic                          ready;
	logic                          event_on;
	logic [wpp_pkg::NOTE_W-1:0]    note_number;
	logic [wpp_pkg::CHANNEL_W-1:0] channel;
	logic [wpp_pkg::CLASS_W-1:0]   picked_class;

	modport source (output valid, event_on, note_number, channel, picked_class, input ready);
	modport sink (input valid, event_on, note_number, channel, picked_class, output ready);
endinterface

@@ design/wpp_argmax.sv @@
`timescale 1ns / 1ps
// compare-select tree finding the heaviest pitch class
// depends on wpp_pkg
module wpp_argmax #(
	parameter int CLASS_COUNT = wpp_pkg::CLASS_COUNT_DEF
) (
	input  logic [wpp_pkg::WEIGHT_W-1:0] weights [CLASS_COUNT],
	input  logic                         scan_down,
	output wpp_pkg::pick_t               pick
);
	localparam int IDX_W  = $clog2(CLASS_COUNT);
	localparam int LEAVES = 1 << IDX_W;

	// heap layout: node n has children 2n (lower classes) and 2n+1
	logic [wpp_pkg::WEIGHT_W-1:0] node_w [1:2*LEAVES-1];
	logic [IDX_W-1:0]             node_i [1:2*LEAVES-1];

	genvar g;
	generate
		for (g = 0; g < LEAVES; g++) begin : g_leaf
			if (g < CLASS_COUNT) begin : g_real
				assign node_w[LEAVES+g] = weights[g];
			end else begin : g_pad
				assign node_w[LEAVES+g] = '0;
			end
			assign node_i[LEAVES+g] = IDX_W'(g);
		end
		for (g = 1; g < LEAVES; g++) begin : g_node
			logic take_hi;
			// upward scan keeps the lower class on a tie, downward the higher one
			assign take_hi = scan_down ? (node_w[2*g+1] >= node_w[2*g])
			                           : (node_w[2*g+1] > node_w[2*g]);
			assign node_w[g] = take_hi ? node_w[2*g+1] : node_w[2*g];
			assign node_i[g] = take_hi ? node_i[2*g+1] : node_i[2*g];
		end
	endgenerate

	assign pick.found = (node_w[1] != '0);
	assign pick.idx   = wpp_pkg::CLASS_W'(node_i[1]);
	assign pick.best  = node_w[1];
endmodule

@@ design/wpp_note_calc.sv @@
`timescale 1ns / 1ps
// note number from class, octave and transpose, clamped to midi range
// depends on wpp_pkg
module wpp_note_calc (
	input  logic [wpp_pkg::CLASS_W-1:0]         pick,
	input  logic [wpp_pkg::OCTAVE_W-1:0]        octave,
	input  logic signed [wpp_pkg::OFFSET_W-1:0] offset,
	output logic [wpp_pkg::NOTE_W-1:0]          note
);
	logic [7:0]        oct_semis;
	logic signed [9:0] sum;

	always_comb begin
		oct_semis = 8'(octave * wpp_pkg::NOTES_PER_OCTAVE);
		sum = signed'({6'b0, pick}) + signed'({2'b0, oct_semis}) + 10'(offset);
		if (sum < 10'sd0) begin
			note = '0;
		end else if (sum > signed'({3'b0, wpp_pkg::NOTE_MAX})) begin
			note = wpp_pkg::NOTE_MAX;
		end else begin
			note = sum[wpp_pkg::NOTE_W-1:0];
		end
	end
endmodule

@@ design/weighted_pitch_picker_gate.sv @@
`timescale 1ns / 1ps
// top level of the weighted pitch picker: config registers, step register,
// weight state and event register; uses wpp_pkg, wpp_step_if, wpp_event_if,
// wpp_argmax and wpp_note_calc
//
//  channel  | dir | word                                          | note
//  ---------+-----+-----------------------------------------------+--------------------
//  step     | in  | step_kind, note_offset, octave_choice         | one word per step
//  note     | out | event_on, note_number, channel, picked_class  | zero or one per step
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata                  | write only, no wait
//
// a step word waits in the step register, where the weight scan,
// note arithmetic and state update run; the event lands in the output
// register at the same edge as the state update.
// one step per cycle is taken while the event register is free or drained.
// reset clears weights, pick, held note and config, channel to 1; no clearing pass.
// a stalled event holds the step register, which in turn drops step.ready.
module weighted_pitch_picker_gate #(
	parameter int CLASS_COUNT = wpp_pkg::CLASS_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wpp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	wpp_step_if.sink                           step,
	wpp_event_if.source                        note
);
	localparam int IDX_W = $clog2(CLASS_COUNT);
	localparam int WW    = wpp_pkg::WEIGHT_W;

	// configuration registers
	logic [WW-1:0]                     drop_amount_q;
	logic [WW-1:0]                     reset_level_q;
	logic [wpp_pkg::OCTAVE_W-1:0]      octave_a_q;
	logic [wpp_pkg::OCTAVE_W-1:0]      octave_b_q;
	logic [wpp_pkg::CFG_DATA_W-1:0]    reload_low_q;
	logic [wpp_pkg::CFG_DATA_W-1:0]    reload_high_q;
	logic [wpp_pkg::CHANNEL_W-1:0]     midi_channel_q;

	// step register
	logic                              valid_s1;
	logic [1:0]                        step_kind_s1;
	logic signed [wpp_pkg::OFFSET_W-1:0] note_offset_s1;
	logic [wpp_pkg::OCTAVE_W-1:0]      octave_choice_s1;

	// picker state
	logic [WW-1:0]                     weights_q [CLASS_COUNT];
	logic [IDX_W-1:0]                  last_pick_q;
	logic                              note_active_q;
	logic [wpp_pkg::NOTE_W-1:0]        held_note_q;

	// event register
	logic                              out_valid_q;
	logic                              event_on_q;
	logic [wpp_pkg::NOTE_W-1:0]        note_number_q;
	logic [wpp_pkg::CHANNEL_W-1:0]     channel_q;
	logic [wpp_pkg::CLASS_W-1:0]       picked_class_q;

	// step-stage logic
	logic                              s1_fire;
	logic                              gen_on;
	logic                              gen_off;
	wpp_pkg::pick_t                    pick;
	logic [IDX_W-1:0]                  new_pick;
	logic [wpp_pkg::NOTE_W-1:0]        calc_note;
	logic [WW-1:0]                     dropped_w;
	logic [WW-1:0]                     check_w;
	logic                              do_reload;
	logic [WW-1:0]                     reload_w [CLASS_COUNT];

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_amount_q  <= '0;
			reset_level_q  <= '0;
			octave_a_q     <= '0;
			octave_b_q     <= '0;
			reload_low_q   <= '0;
			reload_high_q  <= '0;
			midi_channel_q <= wpp_pkg::MIDI_CHANNEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpp_pkg::CFG_DROP_AMOUNT:     drop_amount_q  <= cfg_wdata[WW-1:0];
				wpp_pkg::CFG_RESET_LEVEL:     reset_level_q  <= cfg_wdata[WW-1:0];
				wpp_pkg::CFG_OCTAVE_A:        octave_a_q     <= cfg_wdata[wpp_pkg::OCTAVE_W-1:0];
				wpp_pkg::CFG_OCTAVE_B:        octave_b_q     <= cfg_wdata[wpp_pkg::OCTAVE_W-1:0];
				wpp_pkg::CFG_RELOAD_LOW_SIX:  reload_low_q   <= cfg_wdata;
				wpp_pkg::CFG_RELOAD_HIGH_SIX: reload_high_q  <= cfg_wdata;
				wpp_pkg::CFG_MIDI_CHANNEL:    midi_channel_q <= cfg_wdata[wpp_pkg::CHANNEL_W-1:0];
				default: ;
			endcase
		end
	end

	// reload weights: six classes per register, class 12 and above reload to zero
	genvar g;
	generate
		for (g = 0; g < CLASS_COUNT; g++) begin : g_reload
			if (g < wpp_pkg::CLASSES_PER_REG) begin : g_lo
				assign reload_w[g] = reload_low_q[WW*g +: WW];
			end else if (g < wpp_pkg::RELOAD_CLASSES) begin : g_hi
				assign reload_w[g] = reload_high_q[WW*(g-wpp_pkg::CLASSES_PER_REG) +: WW];
			end else begin : g_zero
				assign reload_w[g] = '0;
			end
		end
	endgenerate

	// the step register moves on whenever the event register has room
	assign s1_fire    = valid_s1 && (!out_valid_q || note.ready);
	assign step.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.ready && step.valid) begin
			step_kind_s1     <= step.step_kind;
			note_offset_s1   <= step.note_offset;
			octave_choice_s1 <= step.octave_choice;
		end
	end

	wpp_argmax #(
		.CLASS_COUNT(CLASS_COUNT)
	) u_argmax (
		.weights  (weights_q),
		.scan_down(octave_a_q > octave_b_q),
		.pick     (pick)
	);

	// with every weight at zero the previous pick stands
	assign new_pick = pick.found ? pick.idx[IDX_W-1:0] : last_pick_q;

	wpp_note_calc u_note_calc (
		.pick  (wpp_pkg::CLASS_W'(new_pick)),
		.octave(octave_choice_s1),
		.offset(note_offset_s1),
		.note  (calc_note)
	);

	always_comb begin
		gen_on  = (step_kind_s1 == wpp_pkg::STEP_NOTE) && !note_active_q;
		gen_off = (step_kind_s1 == wpp_pkg::STEP_REST) && note_active_q;
		// scan winner weight equals the picked weight, also when all are zero
		dropped_w = (pick.best > drop_amount_q) ? (pick.best - drop_amount_q) : '0;
		// reload test looks at the picked class after this step's drop
		check_w   = gen_on ? dropped_w : weights_q[last_pick_q];
		do_reload = (check_w <= reset_level_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				weights_q[i] <= '0;
			end
			last_pick_q   <= '0;
			note_active_q <= 1'b0;
			held_note_q   <= '0;
		end else if (s1_fire) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				if (do_reload) begin
					weights_q[i] <= reload_w[i];
				end else if (gen_on && (new_pick == IDX_W'(i))) begin
					weights_q[i] <= dropped_w;
				end
			end
			if (gen_on) begin
				last_pick_q   <= new_pick;
				note_active_q <= 1'b1;
				held_note_q   <= calc_note;
			end else if (gen_off) begin
				note_active_q <= 1'b0;
			end
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= gen_on || gen_off;
		end else if (note.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			event_on_q     <= gen_on;
			note_number_q  <= gen_on ? calc_note : held_note_q;
			channel_q      <= midi_channel_q;
			picked_class_q <= wpp_pkg::CLASS_W'(gen_on ? new_pick : last_pick_q);
		end
	end

	assign note.valid        = out_valid_q;
	assign note.event_on     = event_on_q;
	assign note.note_number  = note_number_q;
	assign note.channel      = channel_q;
	assign note.picked_class = picked_class_q;

	// the held class always names a real weight
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(last_pick_q) < CLASS_COUNT)
		else $error("last pick outside class range");

	// a note-on sets the active flag
	a_on_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && gen_on) |=> note_active_q)
		else $error("note-on did not mark note active");

	// a note-off carries the note that was held
	a_off_held_note: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && gen_off) |=> (note.valid && !note.event_on
			&& note.note_number == $past(held_note_q)))
		else $error("note-off does not match held note");

	// note-on and note-off never come from the same step
	a_on_off_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(gen_on && gen_off))
		else $error("step produced both note-on and note-off");

endmodule

@@ sim/weighted_pitch_picker_gate_test.sv @@
`timescale 1ns / 1ps
// self-checking test of weighted_pitch_picker_gate: directed and random step words
// with a built-in pitch-pick predictor; needs wpp_pkg, wpp_step_if, wpp_event_if
module weighted_pitch_picker_gate_test;
	import wpp_pkg::*;

	localparam int CLASSES      = CLASS_COUNT_DEF;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_WORDS  = 95;
	// covers step acceptance through the event register, plus margin
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 200000;
	// the unnamed step code, treated as neither by the block
	localparam logic [1:0] STEP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]                 kind;
		logic signed [OFFSET_W-1:0] offset;
		logic [OCTAVE_W-1:0]        octave;
	} step_word_t;

	typedef struct {
		logic                 event_on;
		logic [NOTE_W-1:0]    note_number;
		logic [CHANNEL_W-1:0] channel;
		logic [CLASS_W-1:0]   picked_class;
	} note_event_t;

	// clock, reset and configuration port, all known from time zero
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// step source and event sink drive the channels through these
	logic                src_valid  = 1'b0;
	logic [1:0]          src_kind   = '0;
	logic [OFFSET_W-1:0] src_offset = '0;
	logic [OCTAVE_W-1:0] src_octave = '0;
	logic                sink_ready = 1'b0;

	wpp_step_if  step_bus ();
	wpp_event_if note_bus ();

	assign step_bus.valid         = src_valid;
	assign step_bus.step_kind     = src_kind;
	assign step_bus.note_offset   = src_offset;
	assign step_bus.octave_choice = src_octave;
	assign note_bus.ready         = sink_ready;

	weighted_pitch_picker_gate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (step_bus),
		.note      (note_bus)
	);

	initial forever #6 clk = ~clk;

	// mirror of the block's registers and state
	logic [WEIGHT_W-1:0]   pk_weight [CLASSES] = '{default: '0};
	logic [CLASS_W-1:0]    pk_last   = '0;
	logic                  pk_active = 1'b0;
	logic [NOTE_W-1:0]     pk_held   = '0;
	logic [WEIGHT_W-1:0]   pk_drop   = '0;
	logic [WEIGHT_W-1:0]   pk_level  = '0;
	logic [OCTAVE_W-1:0]   pk_oct_a  = '0;
	logic [OCTAVE_W-1:0]   pk_oct_b  = '0;
	logic [CFG_DATA_W-1:0] pk_reload_lo = '0;
	logic [CFG_DATA_W-1:0] pk_reload_hi = '0;
	logic [CHANNEL_W-1:0]  pk_channel = MIDI_CHANNEL_RST;

	step_word_t  steps_pending [$];
	note_event_t events_due [$];
	step_word_t  cur_step;
	int          steps_queued   = 0;
	int          steps_taken    = 0;
	int          mismatch_cnt   = 0;
	int          cycle_cnt      = 0;
	int          src_gap        = 0;
	int          sink_gap       = 0;
	bit          idle_on        = 1'b1;

	// reload value of one class from the two packed reload registers
	function automatic logic [WEIGHT_W-1:0] reload_weight(int k);
		if (k < CLASSES_PER_REG)
			return pk_reload_lo[WEIGHT_W*k +: WEIGHT_W];
		if (k < RELOAD_CLASSES)
			return pk_reload_hi[WEIGHT_W*(k-CLASSES_PER_REG) +: WEIGHT_W];
		return '0;
	endfunction

	// advance the mirrored state by one accepted step, queue any event it makes
	task automatic pick_and_predict(input step_word_t s);
		logic [WEIGHT_W-1:0] best;
		int note_val, pick_val, oct_val, off_val;
		if (s.kind == STEP_NOTE && !pk_active) begin
			best = '0;
			// only a strictly larger weight moves the pick, so ties go to the scan start
			if (pk_oct_a <= pk_oct_b) begin
				for (int k = 0; k < CLASSES; k++)
					if (pk_weight[k] > best) begin
						best    = pk_weight[k];
						pk_last = CLASS_W'(k);
					end
			end else begin
				for (int k = CLASSES - 1; k >= 0; k--)
					if (pk_weight[k] > best) begin
						best    = pk_weight[k];
						pk_last = CLASS_W'(k);
					end
			end
			pick_val = pk_last;
			oct_val  = s.octave;
			off_val  = s.offset;
			note_val = pick_val + oct_val * NOTES_PER_OCTAVE + off_val;
			if (note_val < 0)
				note_val = 0;
			if (note_val > int'(NOTE_MAX))
				note_val = int'(NOTE_MAX);
			pk_held   = note_val[NOTE_W-1:0];
			pk_active = 1'b1;
			events_due.push_back('{1'b1, pk_held, pk_channel, pk_last});
			pk_weight[pk_last] = (pk_weight[pk_last] > pk_drop) ?
				pk_weight[pk_last] - pk_drop : '0;
		end else if (s.kind == STEP_REST && pk_active) begin
			pk_active = 1'b0;
			events_due.push_back('{1'b0, pk_held, pk_channel, pk_last});
		end
		// reload check follows every step, whatever its kind
		if (pk_weight[pk_last] <= pk_level)
			for (int k = 0; k < CLASSES; k++)
				pk_weight[k] = reload_weight(k);
	endtask

	task automatic push_step(logic [1:0] kind, logic [OFFSET_W-1:0] offset,
			logic [OCTAVE_W-1:0] octave);
		step_word_t s;
		s.kind   = kind;
		s.offset = offset;
		s.octave = octave;
		steps_pending.push_back(s);
		steps_queued++;
	endtask

	// register write at the next edge; the enable stays high across back-to-back writes
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_DROP_AMOUNT:     pk_drop      = val[WEIGHT_W-1:0];
			CFG_RESET_LEVEL:     pk_level     = val[WEIGHT_W-1:0];
			CFG_OCTAVE_A:        pk_oct_a     = val[OCTAVE_W-1:0];
			CFG_OCTAVE_B:        pk_oct_b     = val[OCTAVE_W-1:0];
			CFG_RELOAD_LOW_SIX:  pk_reload_lo = val;
			CFG_RELOAD_HIGH_SIX: pk_reload_hi = val;
			CFG_MIDI_CHANNEL:    pk_channel   = val[CHANNEL_W-1:0];
			default: ;
		endcase
	endtask

	// random junk above the field so the block must ignore the upper bits
	function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] field, int w);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		return CFG_DATA_W'((junk << w) | 64'(field));
	endfunction

	task automatic program_all(int drop, int level, int oct_a, int oct_b,
			logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi, int chan);
		write_reg(CFG_DROP_AMOUNT, with_noise(CFG_DATA_W'(drop), WEIGHT_W));
		write_reg(CFG_RESET_LEVEL, with_noise(CFG_DATA_W'(level), WEIGHT_W));
		write_reg(CFG_OCTAVE_A, with_noise(CFG_DATA_W'(oct_a), OCTAVE_W));
		write_reg(CFG_OCTAVE_B, with_noise(CFG_DATA_W'(oct_b), OCTAVE_W));
		write_reg(CFG_RELOAD_LOW_SIX, lo);
		write_reg(CFG_RELOAD_HIGH_SIX, hi);
		write_reg(CFG_MIDI_CHANNEL, with_noise(CFG_DATA_W'(chan), CHANNEL_W));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// six packed weights; some styles force ties or sparse maxima
	function automatic logic [CFG_DATA_W-1:0] random_reload_word();
		logic [CFG_DATA_W-1:0] word;
		int style;
		word  = '0;
		style = $urandom_range(0, 3);
		for (int k = 0; k < CLASSES_PER_REG; k++)
			case (style)
				0: word[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 127));
				1: word[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 4) * 25);
				2: word[WEIGHT_W*k +: WEIGHT_W] = ($urandom_range(0, 3) == 0) ?
					WEIGHT_W'($urandom_range(1, 127)) : '0;
				default: word[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_W'($urandom_range(40, 47));
			endcase
		return word;
	endfunction

	function automatic logic [OCTAVE_W-1:0] random_octave();
		// mostly inside the musical range, sometimes the out-of-range codes
		if ($urandom_range(0, 4) == 0)
			return OCTAVE_W'($urandom_range(11, 15));
		return OCTAVE_W'($urandom_range(0, 10));
	endfunction

	// mostly note / fillers / rest phrases with random content, the rest raw noise
	task automatic fill_random(int count);
		int start;
		start = steps_queued;
		while (steps_queued - start < count) begin
			if ($urandom_range(0, 9) < 7) begin
				push_step(STEP_NOTE, OFFSET_W'($urandom_range(0, 127)), random_octave());
				repeat ($urandom_range(0, 2))
					case ($urandom_range(0, 2))
						0: push_step(STEP_NOTE, OFFSET_W'($urandom()), OCTAVE_W'($urandom()));
						1: push_step(STEP_NEITHER, OFFSET_W'($urandom()), OCTAVE_W'($urandom()));
						default: push_step(STEP_UNUSED, OFFSET_W'($urandom()),
							OCTAVE_W'($urandom()));
					endcase
				push_step(STEP_REST, OFFSET_W'($urandom()), OCTAVE_W'($urandom()));
			end else begin
				push_step(2'($urandom_range(0, 3)), OFFSET_W'($urandom_range(0, 127)),
					random_octave());
			end
		end
	endtask

	// block idle: every queued word taken, every event seen, then let the pipe settle
	task automatic wait_drained();
		while (steps_taken != steps_queued || events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// step driver: predicts at acceptance, then offers the next word or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (src_valid && step_bus.ready) begin
				pick_and_predict(cur_step);
				steps_taken++;
			end
			if (!src_valid || step_bus.ready) begin
				if (idle_on && src_gap > 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (steps_pending.size() > 0) begin
					cur_step = steps_pending.pop_front();
					src_kind   <= cur_step.kind;
					src_offset <= cur_step.offset;
					src_octave <= cur_step.octave;
					src_valid  <= 1'b1;
					// burst of idle cycles after this word is taken
					if (idle_on && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 18);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor: compare each taken word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		note_event_t want;
		if (!arst_n) begin
			sink_ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (note_bus.valid && sink_ready) begin
				if (events_due.size() == 0) begin
					$error("unexpected event word: on %0d note %0d channel %0d class %0d",
						note_bus.event_on, note_bus.note_number, note_bus.channel,
						note_bus.picked_class);
					mismatch_cnt++;
				end else begin
					want = events_due.pop_front();
					if (note_bus.event_on !== want.event_on) begin
						$error("event_on: expected %0d, got %0d", want.event_on,
							note_bus.event_on);
						mismatch_cnt++;
					end
					if (note_bus.note_number !== want.note_number) begin
						$error("note_number: expected %0d, got %0d", want.note_number,
							note_bus.note_number);
						mismatch_cnt++;
					end
					if (note_bus.channel !== want.channel) begin
						$error("channel: expected %0d, got %0d", want.channel,
							note_bus.channel);
						mismatch_cnt++;
					end
					if (note_bus.picked_class !== want.picked_class) begin
						$error("picked_class: expected %0d, got %0d", want.picked_class,
							note_bus.picked_class);
						mismatch_cnt++;
					end
				end
			end
			// random stall bursts with sink_ready held low
			if (idle_on && sink_gap > 0) begin
				sink_gap--;
				sink_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 17);
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: all weights zero, so the pick stays at class 0
		push_step(STEP_NOTE, 0, 0);
		push_step(STEP_NOTE, 5, 3);       // held note, ignored
		push_step(STEP_REST, 0, 0);
		push_step(STEP_REST, 0, 0);       // nothing held, ignored
		push_step(STEP_NEITHER, 0, 0);
		push_step(STEP_UNUSED, 0, 0);
		push_step(STEP_NOTE, OFFSET_W'(-64), 0);     // clamps low
		push_step(STEP_REST, 0, 0);
		wait_drained();

		// upward scan, classes 1, 2 and 11 tie at 9, full drop forces reloads
		program_all(127, 0, 0, 10, CFG_DATA_W'((9 << 14) | (9 << 7) | 5),
			CFG_DATA_W'(9) << 35, 16);
		push_step(STEP_NEITHER, 0, 0);    // reload from the new words
		push_step(STEP_NOTE, 63, 15);     // clamps high
		push_step(STEP_REST, 0, 0);
		push_step(STEP_NOTE, OFFSET_W'(-64), 0);
		push_step(STEP_REST, 0, 0);
		push_step(STEP_NOTE, 0, 10);
		push_step(STEP_REST, 0, 0);
		wait_drained();

		// downward scan, ties resolve to the highest class, channel zero passed through
		program_all(3, 2, 10, 0, CFG_DATA_W'((9 << 14) | (9 << 7) | 5),
			CFG_DATA_W'(9) << 35, 0);
		push_step(STEP_NEITHER, 0, 0);
		for (int i = 0; i < 5; i++) begin
			push_step(STEP_NOTE, OFFSET_W'(i * 7 - 10), OCTAVE_W'(2 * i));
			push_step(STEP_REST, 0, 0);
		end
		wait_drained();

		// random phases, the last two with no idling on either side
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: program_all(127, 127, 15, 15, '1, '1, 31);
				1: program_all(0, 0, 0, 0, '0, '0, 0);
				2: program_all(0, 0, 0, 10, random_reload_word(), random_reload_word(), 16);
				default: program_all(
					$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 127),
					$urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(0, 127),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 10),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 10),
					random_reload_word(), random_reload_word(), $urandom_range(0, 31));
			endcase
			idle_on = (p < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			fill_random(PHASE_WORDS);
			wait_drained();
		end

		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
design/wpp_pkg.sv
design/wpp_step_if.sv
design/wpp_event_if.sv
design/wpp_argmax.sv
design/wpp_note_calc.sv
design/weighted_pitch_picker_gate.sv
sim/weighted_pitch_picker_gate_test.sv
